// ----- rtl/ppe_pkg.sv -----
// Shared types and codes for the particle pool engine.
// No dependencies; ppe_cell and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

  localparam logic [1:0] OP_EMIT   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] base_vel_x;
    logic signed [31:0] base_vel_y;
    logic signed [31:0] base_vel_z;
    logic [47:0]        jitter_xyz;
    logic [31:0]        tint_from;
    logic [31:0]        tint_to;
    logic [31:0]        scale_pair;
    logic [31:0]        time_value;
  } item_t;

  typedef struct packed {
    logic [5:0]         slot;
    logic signed [31:0] at_x;
    logic signed [31:0] at_y;
    logic signed [31:0] at_z;
    logic [15:0]        quad_size;
    logic [31:0]        quad_color;
    logic               empty_res;
    logic               last;
  } result_t;

  // Everything one pool slot holds.
  typedef struct packed {
    logic               alive;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [31:0]        col_from;
    logic [31:0]        col_to;
    logic [31:0]        sizes;
    logic [31:0]        life_total;
    logic [31:0]        life_left;
  } slot_t;

endpackage

`default_nettype wire

// ----- rtl/ppe_cell.sv -----
// One cell of the slot ring: holds a single particle slot.
// Depends on ppe_pkg for the slot record.
`timescale 1ns / 1ps
`default_nettype none

module ppe_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           shift_i,
  input  wire logic           load_i,
  input  wire ppe_pkg::slot_t nb_i,
  input  wire ppe_pkg::slot_t load_data_i,
  output ppe_pkg::slot_t      q_o
);

  ppe_pkg::slot_t slot_q;

  // The whole slot is cleared at reset; only the alive flag matters to readers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (load_i) begin
      slot_q <= load_data_i;
    end else if (shift_i) begin
      slot_q <= nb_i;
    end
  end

  assign q_o = slot_q;

endmodule

`default_nettype wire

// ----- rtl/ppe_blend_lane.sv -----
// One blend lane: weighted sum of begin and end values, then a 16-step
// restoring division by the total lifetime. Stand-alone, no package use.
`timescale 1ns / 1ps
`default_nettype none

module ppe_blend_lane (
  input  wire logic        clk_i,
  input  wire logic        load_i,
  input  wire logic        step_i,
  input  wire logic [15:0] begin_i,
  input  wire logic [15:0] end_i,
  input  wire logic [31:0] left_i,
  input  wire logic [31:0] total_i,
  output logic      [15:0] quot_o
);

  logic [31:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;
  logic [31:0] den_q;
  logic [47:0] num;
  logic [32:0] trial;
  logic        ge;

  // The quotient lies between the begin and end values, so it fits 16 bits
  // and the upper 32 numerator bits start below the divisor.
  always_comb begin
    num = ({32'd0, begin_i} * {16'd0, left_i})
        + ({32'd0, end_i} * {16'd0, total_i - left_i});
    trial = {rem_q, quo_q[15]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? 32'(trial - {1'b0, den_q}) : trial[31:0];
    quo_d = {quo_q[14:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= num[47:16];
      quo_q <= num[15:0];
      den_q <= total_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/particle_pool_engine_unit.sv -----
// Top level of the particle pool engine: slot ring, control and APB registers.
// Depends on ppe_pkg, ppe_cell and ppe_blend_lane.
//
// The pool lives in a ring of POOL_SIZE cells, one particle slot per cell. An
// emit beat with a nonzero lifetime writes the ring-pointer slot directly, so
// busy stays low and another beat may follow at once. A tick beat rotates the
// whole ring once, aging and moving each slot as it passes the head cell. A
// render beat also rotates the ring once; each live slot halts the ring while
// the blend lanes load and then divide for the color and size blend, and its
// output state moves the ring on. Results appear on result_o for exactly one
// cycle, marked by result_valid_o, and the receiver cannot hold them off; the
// last result of a render carries last = 1, and an empty pool gives a single
// result with empty_res = 1. The spread registers are written over APB at byte
// addresses 0, 4 and 8 and should be changed only while busy is low and no
// result is still due.
`timescale 1ns / 1ps
`default_nettype none

module particle_pool_engine_unit #(
  parameter int POOL_SIZE = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire ppe_pkg::item_t  item_i,
  output logic                 result_valid_o,
  output ppe_pkg::result_t     result_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(POOL_SIZE - 1);
  localparam logic [1:0] REG_X = 2'd0;
  localparam logic [1:0] REG_Y = 2'd1;
  localparam logic [1:0] REG_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TICK, ST_RSCAN, ST_RDIV, ST_ROUT, ST_RFIN
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     next_q;
  logic [3:0]        step_q;
  logic [31:0]       tick_q;
  logic [31:0]       spread_q [3];
  ppe_pkg::result_t  pend_q, res_q;
  logic              pend_v_q, res_v_q;
  ppe_pkg::result_t  fin_res;

  ppe_pkg::slot_t    cell_q [POOL_SIZE];
  ppe_pkg::slot_t    head, head_next, emit_slot;
  logic              accept, shift, end_pass, blend_load, blend_step;
  logic [15:0]       quot [5];

  // Saturate a 50-bit signed value to 32 bits.
  function automatic logic [31:0] sat32(input logic [49:0] v);
    if (v[49:31] == '0 || v[49:31] == '1) begin
      return v[31:0];
    end
    return v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] emit_vel(input logic [31:0] base,
                                           input logic [15:0] jit,
                                           input logic [31:0] spr);
    logic signed [48:0] prod;
    logic [33:0]        var_v;
    prod  = $signed(jit) * $signed({1'b0, spr});
    var_v = 34'(prod >>> 15);
    return sat32({{18{base[31]}}, base} + {{16{var_v[33]}}, var_v});
  endfunction

  function automatic logic [31:0] move(input logic [31:0] pos,
                                       input logic [31:0] vel,
                                       input logic [31:0] dt);
    logic signed [64:0] prod;
    logic [48:0]        d;
    prod = $signed(vel) * $signed({1'b0, dt});
    d    = prod[64:16];
    return sat32({{18{pos[31]}}, pos} + {d[48], d});
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign head   = cell_q[0];

  // New slot contents for an emit.
  always_comb begin
    emit_slot            = '0;
    emit_slot.alive      = 1'b1;
    emit_slot.px         = item_i.start_x;
    emit_slot.py         = item_i.start_y;
    emit_slot.pz         = item_i.start_z;
    emit_slot.vx         = emit_vel(item_i.base_vel_x, item_i.jitter_xyz[15:0],
                                    spread_q[0]);
    emit_slot.vy         = emit_vel(item_i.base_vel_y, item_i.jitter_xyz[31:16],
                                    spread_q[1]);
    emit_slot.vz         = emit_vel(item_i.base_vel_z, item_i.jitter_xyz[47:32],
                                    spread_q[2]);
    emit_slot.col_from   = item_i.tint_from;
    emit_slot.col_to     = item_i.tint_to;
    emit_slot.sizes      = item_i.scale_pair;
    emit_slot.life_total = item_i.time_value;
    emit_slot.life_left  = item_i.time_value;
  end

  // The head cell feeds the tail; during a tick the slot is aged on the way.
  always_comb begin
    head_next = head;
    if (state_q == ST_TICK && head.alive) begin
      if (tick_q >= head.life_left) begin
        head_next.alive = 1'b0;
      end else begin
        head_next.life_left = head.life_left - tick_q;
        head_next.px = move(head.px, head.vx, tick_q);
        head_next.py = move(head.py, head.vy, tick_q);
        head_next.pz = move(head.pz, head.vz, tick_q);
      end
    end
  end

  assign shift = (state_q == ST_TICK) || (state_q == ST_ROUT)
              || (state_q == ST_RSCAN && !head.alive);
  assign end_pass   = shift && (cnt_q == LAST_IDX);
  assign blend_load = (state_q == ST_RSCAN) && head.alive;
  assign blend_step = (state_q == ST_RDIV);

  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_ring
    logic load;
    assign load = accept && (item_i.op == ppe_pkg::OP_EMIT)
               && (item_i.time_value != 32'd0) && (next_q == CW'(i));
    ppe_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .shift_i     (shift),
      .load_i      (load),
      .nb_i        ((i == POOL_SIZE - 1) ? head_next : cell_q[(i + 1) % POOL_SIZE]),
      .load_data_i (emit_slot),
      .q_o         (cell_q[i])
    );
  end

  // Four color channels, R first, then the size.
  for (genvar c = 0; c < 5; c++) begin : g_lane
    logic [15:0] b, e;
    if (c < 4) begin : g_col
      assign b = {8'd0, head.col_from[31-8*c -: 8]};
      assign e = {8'd0, head.col_to[31-8*c -: 8]};
    end else begin : g_size
      assign b = head.sizes[31:16];
      assign e = head.sizes[15:0];
    end
    ppe_blend_lane u_lane (
      .clk_i   (clk_i),
      .load_i  (blend_load),
      .step_i  (blend_step),
      .begin_i (b),
      .end_i   (e),
      .left_i  (head.life_left),
      .total_i (head.life_total),
      .quot_o  (quot[c])
    );
  end

  // Final result of a render: the held-back slot marked last, or the empty marker.
  always_comb begin
    fin_res = pend_q;
    if (!pend_v_q) begin
      fin_res = '0;
    end
    fin_res.empty_res = !pend_v_q;
    fin_res.last      = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      next_q   <= '0;
      step_q   <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      res_v_q <= ((state_q == ST_ROUT) && pend_v_q) || (state_q == ST_RFIN);
      if (shift) begin
        cnt_q <= end_pass ? '0 : cnt_q + 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (item_i.op)
              ppe_pkg::OP_EMIT: begin
                if (item_i.time_value != 32'd0) begin
                  next_q <= (next_q == LAST_IDX) ? '0 : next_q + 1'b1;
                end
              end
              ppe_pkg::OP_TICK: begin
                state_q <= ST_TICK;
              end
              ppe_pkg::OP_RENDER: begin
                pend_v_q <= 1'b0;
                state_q  <= ST_RSCAN;
              end
              default: ;
            endcase
          end
        end
        ST_TICK: begin
          if (end_pass) state_q <= ST_IDLE;
        end
        ST_RSCAN: begin
          if (head.alive) begin
            step_q  <= '0;
            state_q <= ST_RDIV;
          end else if (end_pass) begin
            state_q <= ST_RFIN;
          end
        end
        ST_RDIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == 4'd15) state_q <= ST_ROUT;
        end
        ST_ROUT: begin
          pend_v_q <= 1'b1;
          state_q  <= end_pass ? ST_RFIN : ST_RSCAN;
        end
        ST_RFIN: begin
          pend_v_q <= 1'b0;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload: one result is held back so that the final one can be
  // marked last when the pass ends.
  always_ff @(posedge clk_i) begin
    if (accept) tick_q <= item_i.time_value;
    if (state_q == ST_ROUT) begin
      res_q                 <= pend_q;
      pend_q.slot           <= 6'(cnt_q);
      pend_q.at_x           <= head.px;
      pend_q.at_y           <= head.py;
      pend_q.at_z           <= head.pz;
      pend_q.quad_size      <= quot[4];
      pend_q.quad_color     <= {quot[0][7:0], quot[1][7:0], quot[2][7:0], quot[3][7:0]};
      pend_q.empty_res      <= 1'b0;
      pend_q.last           <= 1'b0;
    end else if (state_q == ST_RFIN) begin
      res_q <= fin_res;
    end
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // APB registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spread_q[0] <= '0;
      spread_q[1] <= '0;
      spread_q[2] <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_X:   spread_q[0] <= pwdata;
        REG_Y:   spread_q[1] <= pwdata;
        REG_Z:   spread_q[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X:   prdata = spread_q[0];
      REG_Y:   prdata = spread_q[1];
      REG_Z:   prdata = spread_q[2];
      default: prdata = '0;
    endcase
  end

  assign pready = 1'b1;

`ifndef NO_ASSERTIONS
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_q.empty_res |-> res_q.last)
    else $error("empty result not marked last");
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && item_i.op == ppe_pkg::OP_TICK |=> busy)
    else $error("tick did not start a ring pass");
  a_div_head_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RDIV |-> head.alive && !shift)
    else $error("ring moved or head died during blend");
  a_last_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_q.last |-> $past(state_q == ST_RFIN))
    else $error("last result outside end of render");
`endif

endmodule

`default_nettype wire

// ----- sim/particle_pool_engine_unit_tb.sv -----
// Self-checking testbench for particle_pool_engine_unit: directed table, then random beats.
// Depends on ppe_pkg and the RTL of particle_pool_engine_unit; needs nothing else.
`timescale 1ns / 1ps

module particle_pool_engine_unit_tb;

  localparam int PoolSize = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [3:0] ADDR_SPREAD_X = 4'd0;
  localparam logic [3:0] ADDR_SPREAD_Y = 4'd4;
  localparam logic [3:0] ADDR_SPREAD_Z = 4'd8;
  localparam logic [3:0] ADDR_UNUSED   = 4'd12;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ppe_pkg::item_t    item_i = '0;
  logic              result_valid_o;
  ppe_pkg::result_t  result_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  particle_pool_engine_unit #(.POOL_SIZE(PoolSize)) uut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the pool, kept in step with every accepted beat.
  logic               pool_alive [PoolSize];
  logic signed [31:0] pool_pos   [PoolSize][3];
  logic signed [31:0] pool_vel   [PoolSize][3];
  logic [31:0]        pool_tint_from [PoolSize];
  logic [31:0]        pool_tint_to   [PoolSize];
  logic [31:0]        pool_sizes     [PoolSize];
  logic [31:0]        pool_life_tot  [PoolSize];
  logic [31:0]        pool_life_rem  [PoolSize];
  logic [5:0]         ring_head;
  logic [31:0]        spread [3];

  ppe_pkg::result_t due_results [$];
  int               mismatches = 0;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] mix(logic [31:0] b, logic [31:0] e,
                                      logic [31:0] rem, logic [31:0] tot);
    longint unsigned acc;
    acc = longint'(b) * longint'(rem) + longint'(e) * longint'(tot - rem);
    return 32'(acc / longint'(tot));
  endfunction

  // Applies one accepted beat to the shadow pool and queues the readout it causes.
  function automatic void advance_pool(ppe_pkg::item_t it);
    logic [5:0]          s;
    longint              prod;
    logic signed [15:0]  jit;
    logic signed [31:0]  base;
    logic [31:0]         t;
    logic [31:0]         col;
    ppe_pkg::result_t    r;
    int                  n;
    t = it.time_value;
    n = 0;
    case (it.op)
      ppe_pkg::OP_EMIT: begin
        if (t == 0) return;
        s = ring_head;
        pool_alive[s] = 1'b1;
        pool_pos[s][0] = it.start_x;
        pool_pos[s][1] = it.start_y;
        pool_pos[s][2] = it.start_z;
        for (int a = 0; a < 3; a++) begin
          jit = it.jitter_xyz[16*a +: 16];
          base = (a == 0) ? it.base_vel_x : (a == 1) ? it.base_vel_y : it.base_vel_z;
          prod = longint'(jit) * longint'({32'd0, spread[a]});
          pool_vel[s][a] = sat32(longint'(base) + (prod >>> 15));
        end
        pool_tint_from[s] = it.tint_from;
        pool_tint_to[s] = it.tint_to;
        pool_sizes[s] = it.scale_pair;
        pool_life_tot[s] = t;
        pool_life_rem[s] = t;
        ring_head = (s == PoolSize - 1) ? 6'd0 : s + 6'd1;
      end
      ppe_pkg::OP_TICK: begin
        for (int k = 0; k < PoolSize; k++) begin
          if (!pool_alive[k]) continue;
          if (t >= pool_life_rem[k]) begin
            pool_alive[k] = 1'b0;
            continue;
          end
          pool_life_rem[k] -= t;
          for (int a = 0; a < 3; a++) begin
            prod = longint'(pool_vel[k][a]) * longint'({32'd0, t});
            pool_pos[k][a] = sat32(longint'(pool_pos[k][a]) + (prod >>> 16));
          end
        end
      end
      ppe_pkg::OP_RENDER: begin
        for (int k = 0; k < PoolSize; k++) begin
          if (!pool_alive[k]) continue;
          for (int c = 0; c < 4; c++)
            col[8*c +: 8] = 8'(mix(pool_tint_from[k][8*c +: 8], pool_tint_to[k][8*c +: 8],
                                   pool_life_rem[k], pool_life_tot[k]));
          r = '0;
          r.slot = 6'(k);
          r.at_x = pool_pos[k][0];
          r.at_y = pool_pos[k][1];
          r.at_z = pool_pos[k][2];
          r.quad_color = col;
          r.quad_size = 16'(mix(pool_sizes[k][31:16], pool_sizes[k][15:0],
                                pool_life_rem[k], pool_life_tot[k]));
          due_results.push_back(r);
          n++;
        end
        if (n == 0) begin
          r = '0;
          r.empty_res = 1'b1;
          r.last = 1'b1;
          due_results.push_back(r);
        end else begin
          due_results[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Every result beat is held against the oldest expected one.
  always @(posedge clk_i) begin
    ppe_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", result_o);
      end else begin
        want = due_results.pop_front();
        if (result_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h, got %h", want, result_o);
        end
      end
    end
  end

  function automatic ppe_pkg::item_t make_item(logic [1:0] op, logic [31:0] px,
                                               logic [31:0] py, logic [31:0] pz,
                                               logic [31:0] vx, logic [31:0] vy,
                                               logic [31:0] vz, logic [47:0] jit,
                                               logic [31:0] c0, logic [31:0] c1,
                                               logic [31:0] sz, logic [31:0] t);
    ppe_pkg::item_t it;
    it.op = op;
    it.start_x = px;
    it.start_y = py;
    it.start_z = pz;
    it.base_vel_x = vx;
    it.base_vel_y = vy;
    it.base_vel_z = vz;
    it.jitter_xyz = jit;
    it.tint_from = c0;
    it.tint_to = c1;
    it.scale_pair = sz;
    it.time_value = t;
    return it;
  endfunction

  function automatic ppe_pkg::item_t random_item(logic [1:0] op);
    logic [31:0] t;
    case ($urandom_range(0, 3))
      0:       t = $urandom;
      1:       t = $urandom_range(0, 16);
      default: t = $urandom_range(0, 32'h0008_0000);
    endcase
    if (op == ppe_pkg::OP_TICK && $urandom_range(0, 7) != 0)
      t = $urandom_range(0, 32'h0002_0000);
    return make_item(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     48'({$urandom, $urandom}), $urandom, $urandom, $urandom, t);
  endfunction

  bit burst = 1'b0;

  // Sends one beat after a random pause; start stays high across back-to-back beats.
  task automatic send_beat(ppe_pkg::item_t it);
    int pause;
    if ($urandom_range(0, 15) == 0) burst = ~burst;
    pause = burst ? 0 : $urandom_range(0, 12);
    if (pause > 0) begin
      start <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    advance_pool(it);
  endtask

  // Waits until the block is quiet, then writes one register over APB.
  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    wait (due_results.size() == 0);
    do @(negedge clk_i); while (busy);
    repeat (100) @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SPREAD_X) spread[0] = value;
    if (addr == ADDR_SPREAD_Y) spread[1] = value;
    if (addr == ADDR_SPREAD_Z) spread[2] = value;
  endtask

  task automatic set_spread(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    write_reg(ADDR_SPREAD_X, sx);
    write_reg(ADDR_SPREAD_Y, sy);
    write_reg(ADDR_SPREAD_Z, sz);
  endtask

  typedef struct {
    ppe_pkg::item_t   it;
    bit               typed;
    ppe_pkg::result_t want;
  } row_t;

  row_t             plan [$];
  ppe_pkg::result_t empty_pool;

  function automatic void add_row(ppe_pkg::item_t it, bit typed = 1'b0);
    row_t r;
    r.it = it;
    r.typed = typed;
    r.want = empty_pool;
    plan.push_back(r);
  endfunction

  initial begin
    logic [1:0] op;
    int         pick;
    for (int k = 0; k < PoolSize; k++) pool_alive[k] = 1'b0;
    ring_head = '0;
    spread = '{default: '0};
    empty_pool = '0;
    empty_pool.empty_res = 1'b1;
    empty_pool.last = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: maximum spread so that both velocity rails are reached.
    set_spread('1, '1, '1);
    write_reg(ADDR_UNUSED, 32'h1234_5678);
    add_row(make_item(ppe_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    add_row(make_item(ppe_pkg::OP_EMIT, 1, 2, 3, 4, 5, 6, 0, '1, 0, '1, 0));
    add_row(make_item(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    add_row(make_item(ppe_pkg::OP_RENDER, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1),
            1'b1);
    add_row(make_item(ppe_pkg::OP_EMIT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 48'h7FFF_7FFF_7FFF,
                      32'hFF00_FF00, 32'h00FF_00FF, 32'hFFFF_0000, '1));
    add_row(make_item(ppe_pkg::OP_EMIT, 32'h80000000, 32'h80000000, 32'h80000000,
                      32'h80000000, 32'h80000000, 32'h80000000, 48'h8000_8000_8000, 0,
                      '1, 32'h0000_FFFF, 32'h0001_0000));
    add_row(make_item(ppe_pkg::OP_EMIT, 0, 0, 0, 0, 0, 0, '1, 32'h1234_5678,
                      32'h8765_4321, 32'h0100_0300, 1));
    add_row(make_item(ppe_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(make_item(ppe_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_8000));
    add_row(make_item(ppe_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFF_0000));
    add_row(make_item(ppe_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_item(ppe_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, '1));
    add_row(make_item(ppe_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    // Overwrite of a live slot: wrap the ring with particles of random lifetimes.
    for (int k = 0; k < PoolSize + 2; k++)
      plan.push_back('{random_item(ppe_pkg::OP_EMIT), 1'b0, '0});
    add_row(make_item(ppe_pkg::OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].typed) begin
        send_beat(plan[i].it);
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %h, got no prediction", i, plan[i].want);
        end else if (due_results[$] !== plan[i].want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %h, got %h", i, plan[i].want,
                     due_results[$]);
        end
      end else begin
        send_beat(plan[i].it);
      end
    end

    // Random part over several spread settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_spread('0, '0, '0);
        1:       set_spread('1, 32'h0001_0000, '0);
        default: set_spread($urandom, $urandom_range(0, 32'h0004_0000), $urandom);
      endcase
      for (int n = 0; n < 44; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) op = ppe_pkg::OP_EMIT;
        else if (pick < 80) op = ppe_pkg::OP_TICK;
        else if (pick < 96) op = ppe_pkg::OP_RENDER;
        else op = OP_UNUSED;
        send_beat(random_item(op));
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    wait (due_results.size() == 0);
    repeat (1500) @(posedge clk_i);
    if (due_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("particle_pool_engine_unit_tb: done, clean");
    end else begin
      $display("particle_pool_engine_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("particle_pool_engine_unit_tb: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ppe_pkg.sv
rtl/ppe_cell.sv
rtl/ppe_blend_lane.sv
rtl/particle_pool_engine_unit.sv
sim/particle_pool_engine_unit_tb.sv
